### rtl/lpu_pkg.sv
// Shared types, constants and saturating helpers for the lens point undistortion block.
package lpu_pkg;

  localparam int INT_W      = 48;
  localparam int FRAC       = 24;
  localparam int HALF       = INT_W / 2;
  localparam int PROD_W     = 2 * INT_W;
  localparam int ITERATIONS = 10;
  localparam int ITER_W     = $clog2(ITERATIONS);
  localparam int MAG_W      = 33;
  localparam int DVD_W      = MAG_W + FRAC;
  localparam int CNT_W      = $clog2(DVD_W);

  typedef logic signed [INT_W-1:0] fix_t;

  localparam fix_t FIX_MAX = {1'b0, {(INT_W-1){1'b1}}};
  localparam fix_t FIX_MIN = {1'b1, {(INT_W-1){1'b0}}};
  localparam fix_t FIX_ONE = {{(INT_W-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};

  typedef struct packed {
    logic              ovf;
    fix_t              val;
  } sres_t;

  typedef struct packed {
    logic              ovf;
    logic [31:0]       val;
  } s32res_t;

  typedef struct packed {
    logic [31:0]        focal_x;
    logic [31:0]        focal_y;
    logic [31:0]        cx;
    logic [31:0]        cy;
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } cfg_t;

  typedef struct packed {
    fix_t x0;
    fix_t y0;
    logic fault;
  } norm_t;

  typedef enum logic [2:0] {
    REG_FOCAL_X, REG_FOCAL_Y, REG_PP, REG_K1, REG_K2, REG_K3, REG_P1, REG_P2
  } reg_idx_t;

  typedef enum logic [2:0] {
    F_IDLE, F_STX, F_WX, F_STY, F_WY
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_ISSUE, B_WAIT, B_DIV, B_DIVW, B_DONE
  } back_state_t;

  typedef enum logic [3:0] {
    OP_X2, OP_Y2, OP_XY, OP_R4, OP_R6, OP_K1, OP_K2, OP_K3,
    OP_TX, OP_DX, OP_TY, OP_DY, OP_X, OP_Y, OP_OU, OP_OV
  } op_t;

  function automatic sres_t add_sat(fix_t a, fix_t b);
    logic signed [INT_W:0] s;
    sres_t r;
    s = {a[INT_W-1], a} + {b[INT_W-1], b};
    r.ovf = s[INT_W] ^ s[INT_W-1];
    r.val = r.ovf ? (s[INT_W] ? FIX_MIN : FIX_MAX) : s[INT_W-1:0];
    return r;
  endfunction

  function automatic sres_t sub_sat(fix_t a, fix_t b);
    logic signed [INT_W:0] s;
    sres_t r;
    s = {a[INT_W-1], a} - {b[INT_W-1], b};
    r.ovf = s[INT_W] ^ s[INT_W-1];
    r.val = r.ovf ? (s[INT_W] ? FIX_MIN : FIX_MAX) : s[INT_W-1:0];
    return r;
  endfunction

  function automatic s32res_t sat32(fix_t v);
    s32res_t r;
    r.ovf = !((&v[INT_W-1:31]) || !(|v[INT_W-1:31]));
    r.val = r.ovf ? (v[INT_W-1] ? 32'h8000_0000 : 32'h7fff_ffff) : v[31:0];
    return r;
  endfunction

endpackage

### rtl/lpu_mul.sv
// Multi-cycle signed fixed-point multiplier with truncation and saturation.
module lpu_mul (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  lpu_pkg::fix_t a,
  input  lpu_pkg::fix_t b,
  output logic          done,
  output lpu_pkg::fix_t res,
  output logic          ovf
);
  import lpu_pkg::*;

  logic [INT_W-1:0]      ma;
  logic [INT_W-1:0]      mb;
  logic                  neg;
  logic [2:0]            step;
  logic                  busy;
  logic [INT_W-1:0]      preg;
  logic [PROD_W-1:0]     acc;
  logic [HALF-1:0]       pa;
  logic [HALF-1:0]       pb;
  logic [PROD_W-1:0]     addend;
  logic [PROD_W-FRAC-1:0] q;
  logic [PROD_W-FRAC-1:0] lim;
  logic                  big;
  logic [INT_W-1:0]      qq;

  always_comb begin
    case (step)
      3'd0:    begin pa = ma[HALF-1:0];     pb = mb[HALF-1:0];     end
      3'd1:    begin pa = ma[HALF-1:0];     pb = mb[INT_W-1:HALF]; end
      3'd2:    begin pa = ma[INT_W-1:HALF]; pb = mb[HALF-1:0];     end
      default: begin pa = ma[INT_W-1:HALF]; pb = mb[INT_W-1:HALF]; end
    endcase
    case (step)
      3'd1:       addend = PROD_W'(preg);
      3'd2, 3'd3: addend = PROD_W'(preg) << HALF;
      default:    addend = PROD_W'(preg) << INT_W;
    endcase
    q   = acc[PROD_W-1:FRAC];
    lim = neg ? (PROD_W-FRAC)'($unsigned(FIX_MIN)) : (PROD_W-FRAC)'(FIX_MAX);
    big = q > lim;
    qq  = big ? lim[INT_W-1:0] : q[INT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ma   <= a[INT_W-1] ? -a : a;
        mb   <= b[INT_W-1] ? -b : b;
        neg  <= a[INT_W-1] ^ b[INT_W-1];
        step <= 3'd0;
        acc  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (step < 3'd4) begin
          preg <= pa * pb;
        end
        if (step != 3'd0 && step < 3'd5) begin
          acc <= acc + addend;
        end
        if (step == 3'd5) begin
          res  <= neg ? -qq : qq;
          ovf  <= big;
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 3'd1;
      end
    end
  end

endmodule

### rtl/lpu_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module lpu_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lpu_pkg::DVD_W-1:0]   dividend,
  input  logic [lpu_pkg::INT_W-1:0]   divisor,
  output logic                        done,
  output logic [lpu_pkg::DVD_W-1:0]   quotient
);
  import lpu_pkg::*;

  logic [INT_W-1:0] rem;
  logic [INT_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [INT_W:0]   trial;
  logic             fit;

  always_comb begin
    trial = {rem, quotient[DVD_W-1]};
    fit   = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
        cnt      <= '0;
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= fit ? INT_W'(trial - {1'b0, dsr}) : trial[INT_W-1:0];
        quotient <= {quotient[DVD_W-2:0], fit};
        cnt      <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DVD_W-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/lpu_front.sv
// Front end: input holding register and normalization by the focal lengths.
module lpu_front (
  input  logic                clk,
  input  logic                rst,
  input  lpu_pkg::cfg_t       cfg,
  input  logic                push,
  input  logic signed [31:0]  pixel_u,
  input  logic signed [31:0]  pixel_v,
  output logic                full,
  output logic                slot_valid,
  output lpu_pkg::norm_t      slot,
  input  logic                take
);
  import lpu_pkg::*;

  front_state_t        state;
  front_state_t        state_next;
  logic                hold_valid;
  logic signed [31:0]  hold_u;
  logic signed [31:0]  hold_v;
  logic signed [31:0]  work_u;
  logic signed [31:0]  work_v;
  fix_t                x0;
  logic                flt;
  logic                load;
  logic                div_start;
  logic                div_done;
  logic [DVD_W-1:0]    quo;
  logic                sel_v;
  logic signed [31:0]  pix;
  logic [31:0]         ctr;
  logic [31:0]         foc;
  logic signed [33:0]  diff;
  logic                neg;
  logic [MAG_W-1:0]    mg;
  logic [DVD_W-1:0]    dvd;
  logic [INT_W-1:0]    dsr;
  logic                q_ovf;
  fix_t                q_val;

  assign full = hold_valid;

  always_comb begin
    sel_v = (state == F_STY) || (state == F_WY);
    pix   = sel_v ? work_v : work_u;
    ctr   = sel_v ? cfg.cy : cfg.cx;
    foc   = sel_v ? cfg.focal_y : cfg.focal_x;
    diff  = {{2{pix[31]}}, pix} - {2'b00, ctr};
    neg   = diff[33];
    mg    = neg ? MAG_W'(-diff) : MAG_W'(diff);
    dvd   = {mg, {FRAC{1'b0}}};
    dsr   = (foc == 32'd0) ? INT_W'(1) : INT_W'(foc);
    if (neg) begin
      q_ovf = quo > DVD_W'($unsigned(FIX_MIN));
      q_val = q_ovf ? FIX_MIN : -quo[INT_W-1:0];
    end else begin
      q_ovf = quo > DVD_W'(FIX_MAX);
      q_val = q_ovf ? FIX_MAX : quo[INT_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      F_IDLE: begin
        if (hold_valid && !slot_valid) begin
          load       = 1'b1;
          state_next = F_STX;
        end
      end
      F_STX: begin
        div_start  = 1'b1;
        state_next = F_WX;
      end
      F_WX: begin
        if (div_done) state_next = F_STY;
      end
      F_STY: begin
        div_start  = 1'b1;
        state_next = F_WY;
      end
      F_WY: begin
        if (div_done) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      slot_valid <= 1'b0;
    end else begin
      if (push && !hold_valid) begin
        hold_valid <= 1'b1;
        hold_u     <= pixel_u;
        hold_v     <= pixel_v;
      end else if (load) begin
        hold_valid <= 1'b0;
      end
      if (load) begin
        work_u <= hold_u;
        work_v <= hold_v;
      end
      if (state == F_WX && div_done) begin
        x0  <= q_val;
        flt <= q_ovf;
      end
      if (state == F_WY && div_done) begin
        slot_valid <= 1'b1;
        slot.x0    <= x0;
        slot.y0    <= q_val;
        slot.fault <= flt | q_ovf;
      end else if (take) begin
        slot_valid <= 1'b0;
      end
    end
  end

  lpu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .done     (div_done),
    .quotient (quo)
  );

endmodule

### rtl/lpu_back.sv
// Back end: iterative distortion removal, pixel mapping and result register.
module lpu_back (
  input  logic                clk,
  input  logic                rst,
  input  lpu_pkg::cfg_t       cfg,
  input  logic                slot_valid,
  input  lpu_pkg::norm_t      slot,
  output logic                take,
  input  logic                pop,
  output logic                empty,
  output logic signed [31:0]  corrected_u,
  output logic signed [31:0]  corrected_v,
  output logic                range_fault
);
  import lpu_pkg::*;

  back_state_t      state;
  back_state_t      state_next;
  op_t              op;
  op_t              op_next;
  logic [ITER_W-1:0] iter;
  logic [ITER_W-1:0] iter_next;
  fix_t             x0, y0, x, y, x2, y2, xy, r2, r4, r6, den, dx, dy, k;
  logic             flt;
  logic [31:0]      ou;
  logic [31:0]      ov;
  logic             out_valid;
  logic             mul_start;
  logic             mul_done;
  fix_t             mres;
  logic             mul_ovf;
  logic             div_start;
  logic             div_done;
  logic [DVD_W-1:0] quo;
  fix_t             opa;
  fix_t             opb;
  logic             opnd_ovf;
  sres_t            sa1, sa2, sb1, sb2, sx, sy;
  fix_t             ua;
  fix_t             ub;
  sres_t            upd;
  s32res_t          s32;
  logic             last_iter;
  logic             den_bad;
  logic             k_ovf;
  logic             deliver;
  fix_t             fx48, fy48, cx48, cy48;

  assign empty       = !out_valid;
  assign last_iter   = iter == ITER_W'(ITERATIONS - 1);
  assign den_bad     = den[INT_W-1] || (den == '0);
  assign k_ovf       = quo > DVD_W'(FIX_MAX);
  assign deliver     = (state == B_DONE) && (!out_valid || pop);
  assign fx48        = fix_t'({16'd0, cfg.focal_x});
  assign fy48        = fix_t'({16'd0, cfg.focal_y});
  assign cx48        = fix_t'({16'd0, cfg.cx});
  assign cy48        = fix_t'({16'd0, cfg.cy});

  always_comb begin
    sa1 = add_sat(x2, x2);
    sa2 = add_sat(r2, sa1.val);
    sb1 = add_sat(y2, y2);
    sb2 = add_sat(r2, sb1.val);
    sx  = sub_sat(x0, dx);
    sy  = sub_sat(y0, dy);
    opnd_ovf = 1'b0;
    case (op)
      OP_X2:   begin opa = x;              opb = x;  end
      OP_Y2:   begin opa = y;              opb = y;  end
      OP_XY:   begin opa = x;              opb = y;  end
      OP_R4:   begin opa = r2;             opb = r2; end
      OP_R6:   begin opa = r4;             opb = r2; end
      OP_K1:   begin opa = fix_t'(cfg.k1); opb = r2; end
      OP_K2:   begin opa = fix_t'(cfg.k2); opb = r4; end
      OP_K3:   begin opa = fix_t'(cfg.k3); opb = r6; end
      OP_TX:   begin opa = fix_t'(cfg.p1); opb = xy; end
      OP_DX:   begin
        opa = fix_t'(cfg.p2); opb = sa2.val; opnd_ovf = sa1.ovf | sa2.ovf;
      end
      OP_TY:   begin opa = fix_t'(cfg.p2); opb = xy; end
      OP_DY:   begin
        opa = fix_t'(cfg.p1); opb = sb2.val; opnd_ovf = sb1.ovf | sb2.ovf;
      end
      OP_X:    begin opa = sx.val; opb = k; opnd_ovf = sx.ovf; end
      OP_Y:    begin opa = sy.val; opb = k; opnd_ovf = sy.ovf; end
      OP_OU:   begin opa = x;              opb = fx48; end
      default: begin opa = y;              opb = fy48; end
    endcase
    case (op)
      OP_Y2:        begin ua = x2;      ub = mres; end
      OP_K1:        begin ua = FIX_ONE; ub = mres; end
      OP_K2, OP_K3: begin ua = den;     ub = mres; end
      OP_TX, OP_TY: begin ua = mres;    ub = mres; end
      OP_DX:        begin ua = dx;      ub = mres; end
      OP_DY:        begin ua = dy;      ub = mres; end
      OP_OU:        begin ua = mres;    ub = cx48; end
      OP_OV:        begin ua = mres;    ub = cy48; end
      default:      begin ua = mres;    ub = '0;   end
    endcase
    upd = add_sat(ua, ub);
    s32 = sat32(upd.val);
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    iter_next  = iter;
    take       = 1'b0;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (slot_valid) begin
          take       = 1'b1;
          op_next    = OP_X2;
          iter_next  = '0;
          state_next = B_ISSUE;
        end
      end
      B_ISSUE: begin
        mul_start  = 1'b1;
        state_next = B_WAIT;
      end
      B_WAIT: begin
        if (mul_done) begin
          state_next = B_ISSUE;
          if ((op == OP_DY && den_bad) || op == OP_Y) begin
            if (last_iter) begin
              op_next = OP_OU;
            end else begin
              op_next   = OP_X2;
              iter_next = iter + ITER_W'(1);
            end
          end else if (op == OP_DY) begin
            state_next = B_DIV;
          end else if (op == OP_OV) begin
            state_next = B_DONE;
          end else begin
            op_next = op_t'(op + 4'd1);
          end
        end
      end
      B_DIV: begin
        div_start  = 1'b1;
        state_next = B_DIVW;
      end
      B_DIVW: begin
        if (div_done) begin
          op_next    = OP_X;
          state_next = B_ISSUE;
        end
      end
      B_DONE: begin
        if (!out_valid || pop) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      op        <= OP_X2;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      iter  <= iter_next;
      if (deliver) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      x0  <= slot.x0;
      y0  <= slot.y0;
      x   <= slot.x0;
      y   <= slot.y0;
      flt <= slot.fault;
    end
    if (state == B_ISSUE) begin
      flt <= flt | opnd_ovf;
    end
    if (state == B_WAIT && mul_done) begin
      flt <= flt | mul_ovf | upd.ovf | ((op == OP_DY) && den_bad) |
             (((op == OP_OU) || (op == OP_OV)) && s32.ovf);
      case (op)
        OP_X2: x2 <= mres;
        OP_Y2: begin
          y2 <= mres;
          r2 <= upd.val;
        end
        OP_XY: xy <= mres;
        OP_R4: r4 <= mres;
        OP_R6: r6 <= mres;
        OP_K1, OP_K2, OP_K3: den <= upd.val;
        OP_TX, OP_DX: dx <= upd.val;
        OP_TY, OP_DY: dy <= upd.val;
        OP_X:  x  <= mres;
        OP_Y:  y  <= mres;
        OP_OU: ou <= s32.val;
        default: ov <= s32.val;
      endcase
    end
    if (state == B_DIVW && div_done) begin
      k   <= k_ovf ? FIX_MAX : quo[INT_W-1:0];
      flt <= flt | k_ovf;
    end
    if (deliver) begin
      corrected_u <= ou;
      corrected_v <= ov;
      range_fault <= flt;
    end
  end

  lpu_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (opa),
    .b     (opb),
    .done  (mul_done),
    .res   (mres),
    .ovf   (mul_ovf)
  );

  lpu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (DVD_W'(1) << (2 * FRAC)),
    .divisor  (den),
    .done     (div_done),
    .quotient (quo)
  );

endmodule

### rtl/lens_point_undistortion.sv
// Top level of the lens point undistortion block: registers, front and back ends.
//
//   channel   ports                                   handshake
//   input     pixel_u, pixel_v                        push / full
//   result    corrected_u, corrected_v, range_fault   pop / empty
//   config    wr_index, wr_data                       wr_en
//
// An item runs ITERATIONS passes (ten) through the back end, which has a shared
// multiplier and a 57-step divider.
// A pass with a non-positive divisor skips the divide and both updates.
// Normalization in the front end (two divides) overlaps the back end.
// One item waits in the input register and one between front and back.
// rst clears all control state; the result register holds until popped.
module lens_point_undistortion (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] pixel_u,
  input  logic signed [31:0] pixel_v,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] corrected_u,
  output logic signed [31:0] corrected_v,
  output logic               range_fault,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [63:0]        wr_data
);
  import lpu_pkg::*;

  cfg_t  cfg;
  logic  slot_valid;
  norm_t slot;
  logic  take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_x <= 32'd32768000;
      cfg.focal_y <= 32'd32768000;
      cfg.cx      <= 32'h0140_0000;
      cfg.cy      <= 32'h00f0_0000;
      cfg.k1      <= '0;
      cfg.k2      <= '0;
      cfg.k3      <= '0;
      cfg.p1      <= '0;
      cfg.p2      <= '0;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_FOCAL_X: cfg.focal_x <= wr_data[31:0];
        REG_FOCAL_Y: cfg.focal_y <= wr_data[31:0];
        REG_PP: begin
          cfg.cx <= wr_data[31:0];
          cfg.cy <= wr_data[63:32];
        end
        REG_K1:  cfg.k1 <= wr_data[31:0];
        REG_K2:  cfg.k2 <= wr_data[31:0];
        REG_K3:  cfg.k3 <= wr_data[31:0];
        REG_P1:  cfg.p1 <= wr_data[31:0];
        default: cfg.p2 <= wr_data[31:0];
      endcase
    end
  end

  lpu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .pixel_u    (pixel_u),
    .pixel_v    (pixel_v),
    .full       (full),
    .slot_valid (slot_valid),
    .slot       (slot),
    .take       (take)
  );

  lpu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .slot_valid  (slot_valid),
    .slot        (slot),
    .take        (take),
    .pop         (pop),
    .empty       (empty),
    .corrected_u (corrected_u),
    .corrected_v (corrected_v),
    .range_fault (range_fault)
  );

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    push && !full |=> full)
    else $error("accepted item did not occupy the input register");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(corrected_u) && $stable(range_fault))
    else $error("waiting result changed before pop");

endmodule
